// ----- rtl/c8_pkg.sv -----
// c8_pkg: shared types, constants and the font table for the interpreter
// no dependencies; used by c8_ctrl, c8_dpath and the top level
package c8_pkg;

   localparam int MemBytes   = 4096;
   localparam int AddrW      = 12;
   localparam int StackDepth = 16;
   localparam int FontBytes  = 80;
   localparam int FrameRows  = 32;
   localparam int RowW       = 5;
   localparam int CntW       = 5;
   localparam logic [AddrW-1:0] PcStart = 12'h200;

   // request operation codes
   localparam logic [1:0] OP_EXEC  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_ROW   = 2'd2;
   localparam logic [1:0] OP_IDLE  = 2'd3;

   localparam logic [7:0] Glyphs [FontBytes] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // datapath micro-operations issued by the controller
   typedef enum logic [3:0] {
      CMD_NOP, CMD_CLEAR, CMD_LATCH, CMD_MEM_WRITE, CMD_ROW_READ,
      CMD_FETCH_HI, CMD_FETCH_LO, CMD_READ_X, CMD_READ_Y, CMD_STEP, CMD_FINISH
   } dp_op_type;

   typedef enum logic [2:0] {
      KIND_SIMPLE, KIND_DRAW, KIND_BCD, KIND_STORE, KIND_LOAD
   } exec_kind_type;

   typedef struct packed {
      dp_op_type       op;
      logic [CntW-1:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic            clr_last;
      exec_kind_type   kind;
      logic [CntW-1:0] limit;
   } dp_stat_type;

   // power-up content of program memory
   function automatic logic [7:0] font_init(input logic [AddrW-1:0] addr);
      logic [7:0] val;
      val = 8'h00;
      if (addr < AddrW'(FontBytes)) begin
         val = Glyphs[addr[6:0]];
      end
      return val;
   endfunction

endpackage

// ----- rtl/bytecode_vm_cpu_with_sprite_display.sv -----
// bytecode_vm_cpu_with_sprite_display: top level of the CHIP-8 interpreter
// depends on c8_pkg, c8_ctrl and c8_dpath
//
//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    operation, address, data, row, keys, random
//  rsp_      out        rsp_valid/rsp_ready    pc, opcode, flags, status, row pixels
//
// after reset the program memory is swept once (font then zeros)
// and no request is taken until the sweep ends
// execute: fetch of the high and low opcode bytes, reads of vx and vy, then
// repeated step states for a draw, BCD, register store or load, then finish;
// the single program memory port keeps these in sequence; memory write and row read use one state before finish
// one request at a time; a finished result waits in the output register while
// the next request is accepted, and a stalled result holds the finish step
module bytecode_vm_cpu_with_sprite_display
   import c8_pkg::*;
#(
   parameter int STACK_DEPTH = StackDepth
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic [AddrW-1:0] req_mem_address,
   input  logic [7:0]       req_write_data,
   input  logic [RowW-1:0]  req_row_select,
   input  logic [15:0]      req_keypad,
   input  logic [7:0]       req_random_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [AddrW-1:0] rsp_program_counter,
   output logic [15:0]      rsp_fetched_opcode,
   output logic             rsp_screen_changed,
   output logic             rsp_sound_on,
   output logic             rsp_waiting_key,
   output logic             rsp_status,
   output logic [63:0]      rsp_row_pixels
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   c8_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   // state and execute datapath
   c8_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_operation),
      .req_mem_address     (req_mem_address),
      .req_write_data      (req_write_data),
      .req_row_select      (req_row_select),
      .req_keypad          (req_keypad),
      .req_random_byte     (req_random_byte),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_program_counter (rsp_program_counter),
      .rsp_fetched_opcode  (rsp_fetched_opcode),
      .rsp_screen_changed  (rsp_screen_changed),
      .rsp_sound_on        (rsp_sound_on),
      .rsp_waiting_key     (rsp_waiting_key),
      .rsp_status          (rsp_status),
      .rsp_row_pixels      (rsp_row_pixels)
   );

   // one request in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // an unknown opcode never touches the display
   a_bad_no_draw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_screen_changed)
      else $error("unknown opcode reported a display change");

   // key wait only comes from the key-wait instruction
   a_wait_opcode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_waiting_key) |->
         (rsp_fetched_opcode[15:12] == 4'hF && rsp_fetched_opcode[7:0] == 8'h0A))
      else $error("key wait reported for another opcode");

   // row pixels only on a row read, which carries no opcode
   a_row_no_opcode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_pixels != 64'd0) |-> (rsp_fetched_opcode == 16'd0))
      else $error("row pixels reported with an executed opcode");

endmodule

// ----- rtl/c8_ctrl.sv -----
// c8_ctrl: sequencer for memory clearing, fetch, decode steps and result hand-off
// depends on c8_pkg
module c8_ctrl
   import c8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_operation,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE, ST_ROW, ST_FETCH_HI, ST_FETCH_LO,
      ST_READ_X, ST_READ_Y, ST_STEP, ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = CMD_NOP;
      cmd.cnt      = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = CMD_CLEAR;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = CMD_LATCH;
               case (req_operation)
                  OP_EXEC:  state_in = ST_FETCH_HI;
                  OP_WRITE: state_in = ST_WRITE;
                  OP_ROW:   state_in = ST_ROW;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_WRITE: begin
            cmd.op   = CMD_MEM_WRITE;
            state_in = ST_FINISH;
         end
         ST_ROW: begin
            cmd.op   = CMD_ROW_READ;
            state_in = ST_FINISH;
         end
         ST_FETCH_HI: begin
            cmd.op   = CMD_FETCH_HI;
            state_in = ST_FETCH_LO;
         end
         ST_FETCH_LO: begin
            cmd.op   = CMD_FETCH_LO;
            state_in = ST_READ_X;
         end
         ST_READ_X: begin
            cmd.op   = CMD_READ_X;
            state_in = ST_READ_Y;
         end
         ST_READ_Y: begin
            cmd.op = CMD_READ_Y;
            cnt_in = '0;
            if (stat.kind == KIND_SIMPLE) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.op = CMD_STEP;
            if (cnt_ff == stat.limit) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.op       = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/c8_dpath.sv -----
// c8_dpath: architectural state, program memory, frame store and execute logic
// depends on c8_pkg; driven by c8_ctrl commands
module c8_dpath
   import c8_pkg::*;
#(
   parameter int STACK_DEPTH = StackDepth
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_operation,
   input  logic [AddrW-1:0]  req_mem_address,
   input  logic [7:0]        req_write_data,
   input  logic [RowW-1:0]   req_row_select,
   input  logic [15:0]       req_keypad,
   input  logic [7:0]        req_random_byte,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic [AddrW-1:0]  rsp_program_counter,
   output logic [15:0]       rsp_fetched_opcode,
   output logic              rsp_screen_changed,
   output logic              rsp_sound_on,
   output logic              rsp_waiting_key,
   output logic              rsp_status,
   output logic [63:0]       rsp_row_pixels
);

   localparam int StkW = $clog2(STACK_DEPTH);
   localparam logic [StkW-1:0] StkLast = StkW'(STACK_DEPTH - 1);

   // memories
   logic [7:0]  mem [MemBytes];
   logic [63:0] frame [FrameRows];
   logic [AddrW-1:0] stack [STACK_DEPTH];

   // architectural state
   logic [7:0]       regs_ff [16];
   logic [AddrW-1:0] pc_ff, i_ff;
   logic [StkW-1:0]  sp_ff;
   logic [7:0]       dt_ff, st_ff;
   logic [FrameRows-1:0] fvld_ff;
   logic [STACK_DEPTH-1:0] svld_ff;
   logic [AddrW-1:0] clr_ff;

   // latched request and work registers
   logic [1:0]       op_ff;
   logic [AddrW-1:0] addr_ff;
   logic [7:0]       wdata_ff, rand_ff;
   logic [RowW-1:0]  rsel_ff;
   logic [15:0]      keys_ff;
   logic [7:0]       opc_hi_ff, opc_lo_ff, vx_ff, vy_ff, mem_q_ff;
   logic [63:0]      frame_q_ff;
   logic             frame_ok_ff, hit_ff;
   logic [RowW-1:0]  row_d_ff;
   logic [AddrW-1:0] stk_q_ff;

   // result register
   logic [AddrW-1:0] res_pc_ff;
   logic [15:0]      res_opc_ff;
   logic             res_chg_ff, res_snd_ff, res_wait_ff, res_bad_ff;
   logic [63:0]      res_row_ff;

   logic [15:0] opc;
   logic [3:0]  x, y, n;
   logic [7:0]  kk;
   logic [AddrW-1:0] nnn;
   exec_kind_type kind;

   assign opc = {opc_hi_ff, opc_lo_ff};
   assign x   = opc[11:8];
   assign y   = opc[7:4];
   assign n   = opc[3:0];
   assign kk  = opc[7:0];
   assign nnn = opc[11:0];

   // instruction class for the sequencer
   always_comb begin
      kind       = KIND_SIMPLE;
      stat.limit = '0;
      if (opc[15:12] == 4'hD) begin
         kind       = KIND_DRAW;
         stat.limit = {1'b0, n};
      end else if (opc[15:12] == 4'hF && kk == 8'h33) begin
         kind       = KIND_BCD;
         stat.limit = CntW'(2);
      end else if (opc[15:12] == 4'hF && kk == 8'h55) begin
         kind       = KIND_STORE;
         stat.limit = {1'b0, x};
      end else if (opc[15:12] == 4'hF && kk == 8'h65) begin
         kind       = KIND_LOAD;
         stat.limit = {1'b0, x} + 1'b1;
      end
      stat.kind     = kind;
      stat.clr_last = (clr_ff == AddrW'(MemBytes - 1));
   end

   // register file read port
   logic [3:0] rd_idx;
   logic [7:0] reg_q;
   always_comb begin
      case (cmd.op)
         CMD_READ_X: rd_idx = opc_hi_ff[3:0];
         CMD_READ_Y: rd_idx = opc_lo_ff[7:4];
         CMD_STEP:   rd_idx = cmd.cnt[3:0];
         default:    rd_idx = 4'd0;
      endcase
   end
   assign reg_q = regs_ff[rd_idx];

   // decimal digits of vx
   logic [1:0]  bcd_h;
   logic [6:0]  bcd_r;
   logic [14:0] bcd_prod;
   logic [3:0]  bcd_t, bcd_o;
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_h = 2'd2;
         bcd_r = 7'(vx_ff - 8'd200);
      end else if (vx_ff >= 8'd100) begin
         bcd_h = 2'd1;
         bcd_r = 7'(vx_ff - 8'd100);
      end else begin
         bcd_h = 2'd0;
         bcd_r = vx_ff[6:0];
      end
      bcd_prod = 15'(bcd_r) * 15'd205;
      bcd_t    = bcd_prod[14:11];
      bcd_o    = 4'(bcd_r - 7'({bcd_t, 3'b000} + {bcd_t, 1'b0}));
   end

   // sprite byte placed at column vx, wrapping at the right edge
   logic [63:0]  sprite_m;
   logic [127:0] sprite_dbl;
   logic [63:0]  frame_old;
   assign sprite_dbl = {mem_q_ff, 56'd0, mem_q_ff, 56'd0} >> vx_ff[5:0];
   assign sprite_m   = sprite_dbl[63:0];
   assign frame_old  = frame_ok_ff ? frame_q_ff : 64'd0;

   // memory and frame port steering
   logic             mem_we, fr_we, fr_re;
   logic [AddrW-1:0] mem_wa, mem_ra, i_cnt;
   logic [7:0]       mem_wd;
   logic [RowW-1:0]  fr_ra;
   logic [7:0]       bcd_digit;
   logic             step_rd, step_wr;
   assign i_cnt   = i_ff + AddrW'(cmd.cnt);
   assign step_rd = (cmd.cnt < stat.limit);
   assign step_wr = (cmd.cnt != '0);

   always_comb begin
      case (cmd.cnt[1:0])
         2'd0:    bcd_digit = {6'd0, bcd_h};
         2'd1:    bcd_digit = {4'd0, bcd_t};
         default: bcd_digit = {4'd0, bcd_o};
      endcase
      mem_we = 1'b0;
      mem_wa = i_cnt;
      mem_wd = 8'h00;
      mem_ra = pc_ff;
      fr_re  = 1'b0;
      fr_ra  = rsel_ff;
      fr_we  = 1'b0;
      case (cmd.op)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = font_init(clr_ff);
         end
         CMD_MEM_WRITE: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = wdata_ff;
         end
         CMD_ROW_READ: fr_re = 1'b1;
         CMD_FETCH_LO: mem_ra = pc_ff + 1'b1;
         CMD_STEP: begin
            mem_ra = i_cnt;
            case (kind)
               KIND_DRAW: begin
                  fr_re = step_rd;
                  fr_ra = RowW'(vy_ff + 8'(cmd.cnt));
                  fr_we = step_wr;
               end
               KIND_BCD: begin
                  mem_we = 1'b1;
                  mem_wd = bcd_digit;
               end
               KIND_STORE: begin
                  mem_we = 1'b1;
                  mem_wd = reg_q;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // program memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem[mem_ra];
   end

   // frame store rows
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame[row_d_ff] <= frame_old ^ sprite_m;
      end
      if (fr_re) begin
         frame_q_ff  <= frame[fr_ra];
         frame_ok_ff <= fvld_ff[fr_ra];
         row_d_ff    <= fr_ra;
      end
   end

   // execute: next pc, register writes, timers
   logic [AddrW-1:0] pc_next, i_next;
   logic [StkW-1:0]  sp_next, sp_pop;
   logic             push, bad, chg, waiting, clr_frame;
   logic             wr_x, wr_f, dt_set, st_set, i_set;
   logic [7:0]       x_val, f_val, dt_a, st_a, dt_next, st_next;
   logic [8:0]       sum9;
   logic [AddrW:0]   sum_i;
   logic [3:0]       key_idx;
   logic [AddrW-1:0] pc2, pc4;

   assign sp_pop = (sp_ff == '0) ? StkLast : sp_ff - 1'b1;
   assign pc2    = pc_ff + AddrW'(2);
   assign pc4    = pc_ff + AddrW'(4);
   assign sum_i  = {1'b0, i_ff} + {5'd0, vx_ff};

   always_comb begin
      key_idx = 4'd0;
      for (int k = 0; k < 16; k++) begin
         if (keys_ff[k]) begin
            key_idx = 4'(k);
         end
      end
   end

   always_comb begin
      pc_next   = pc2;
      i_next    = i_ff;
      i_set     = 1'b0;
      sp_next   = sp_ff;
      push      = 1'b0;
      bad       = 1'b0;
      chg       = 1'b0;
      waiting   = 1'b0;
      clr_frame = 1'b0;
      wr_x      = 1'b0;
      x_val     = 8'h00;
      wr_f      = 1'b0;
      f_val     = 8'h00;
      dt_set    = 1'b0;
      st_set    = 1'b0;
      sum9      = 9'd0;
      case (opc[15:12])
         4'h0: begin
            if (opc == 16'h00E0) begin
               clr_frame = 1'b1;
               chg       = 1'b1;
            end else if (opc == 16'h00EE) begin
               sp_next = sp_pop;
               pc_next = stk_q_ff + AddrW'(2);
            end else begin
               bad = 1'b1;
            end
         end
         4'h1: pc_next = nnn;
         4'h2: begin
            push    = 1'b1;
            sp_next = (sp_ff == StkLast) ? '0 : sp_ff + 1'b1;
            pc_next = nnn;
         end
         4'h3: if (vx_ff == kk) pc_next = pc4;
         4'h4: if (vx_ff != kk) pc_next = pc4;
         4'h5: begin
            if (n != 4'd0) bad = 1'b1;
            else if (vx_ff == vy_ff) pc_next = pc4;
         end
         4'h6: begin
            wr_x  = 1'b1;
            x_val = kk;
         end
         4'h7: begin
            wr_x  = 1'b1;
            x_val = vx_ff + kk;
         end
         4'h8: begin
            wr_x = 1'b1;
            case (n)
               4'h0: x_val = vy_ff;
               4'h1: x_val = vx_ff | vy_ff;
               4'h2: x_val = vx_ff & vy_ff;
               4'h3: x_val = vx_ff ^ vy_ff;
               4'h4: begin
                  sum9  = {1'b0, vx_ff} + {1'b0, vy_ff};
                  x_val = sum9[7:0];
                  wr_f  = 1'b1;
                  f_val = {7'd0, sum9[8]};
               end
               4'h5: begin
                  x_val = vx_ff - vy_ff;
                  wr_f  = 1'b1;
                  f_val = {7'd0, vx_ff >= vy_ff};
               end
               4'h6: begin
                  x_val = {1'b0, vx_ff[7:1]};
                  wr_f  = 1'b1;
                  f_val = {7'd0, vx_ff[0]};
               end
               4'h7: begin
                  x_val = vy_ff - vx_ff;
                  wr_f  = 1'b1;
                  f_val = {7'd0, vy_ff >= vx_ff};
               end
               4'hE: begin
                  x_val = {vx_ff[6:0], 1'b0};
                  wr_f  = 1'b1;
                  f_val = {7'd0, vx_ff[7]};
               end
               default: begin
                  wr_x = 1'b0;
                  bad  = 1'b1;
               end
            endcase
         end
         4'h9: begin
            if (n != 4'd0) bad = 1'b1;
            else if (vx_ff != vy_ff) pc_next = pc4;
         end
         4'hA: begin
            i_set  = 1'b1;
            i_next = nnn;
         end
         4'hB: pc_next = nnn + AddrW'(reg_q);
         4'hC: begin
            wr_x  = 1'b1;
            x_val = kk & rand_ff;
         end
         4'hD: begin
            wr_f  = 1'b1;
            f_val = {7'd0, hit_ff};
            chg   = 1'b1;
         end
         4'hE: begin
            if (kk == 8'h9E) begin
               if (keys_ff[vx_ff[3:0]]) pc_next = pc4;
            end else if (kk == 8'hA1) begin
               if (!keys_ff[vx_ff[3:0]]) pc_next = pc4;
            end else begin
               bad = 1'b1;
            end
         end
         default: begin
            case (kk)
               8'h07: begin
                  wr_x  = 1'b1;
                  x_val = dt_ff;
               end
               8'h0A: begin
                  if (keys_ff == 16'd0) begin
                     waiting = 1'b1;
                     pc_next = pc_ff;
                  end else begin
                     wr_x  = 1'b1;
                     x_val = {4'd0, key_idx};
                  end
               end
               8'h15: dt_set = 1'b1;
               8'h18: st_set = 1'b1;
               8'h1E: begin
                  wr_f   = 1'b1;
                  f_val  = {7'd0, sum_i[AddrW]};
                  i_set  = 1'b1;
                  i_next = sum_i[AddrW-1:0];
               end
               8'h29: begin
                  i_set  = 1'b1;
                  i_next = AddrW'({vx_ff[3:0], 2'b00}) + AddrW'(vx_ff[3:0]);
               end
               8'h33: ;
               8'h55, 8'h65: begin
                  i_set  = 1'b1;
                  i_next = i_ff + AddrW'(x) + 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
      endcase
      if (bad) begin
         pc_next = pc_ff;
      end
      dt_a    = dt_set ? vx_ff : dt_ff;
      st_a    = st_set ? vx_ff : st_ff;
      dt_next = (dt_a != 8'd0) ? dt_a - 1'b1 : 8'd0;
      st_next = (st_a != 8'd0) ? st_a - 1'b1 : 8'd0;
   end

   logic fin_exec;
   assign fin_exec = (cmd.op == CMD_FINISH) && (op_ff == OP_EXEC);

   // return stack storage with registered read
   always_ff @(posedge clock) begin
      if (fin_exec && push) begin
         stack[sp_ff] <= pc_ff;
      end
      if (cmd.op == CMD_READ_Y) begin
         stk_q_ff <= svld_ff[sp_pop] ? stack[sp_pop] : '0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PcStart;
         i_ff    <= '0;
         sp_ff   <= '0;
         dt_ff   <= '0;
         st_ff   <= '0;
         fvld_ff <= '0;
         svld_ff <= '0;
         clr_ff  <= '0;
         for (int r = 0; r < 16; r++) begin
            regs_ff[r] <= 8'h00;
         end
      end else begin
         if (cmd.op == CMD_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (fr_we) begin
            fvld_ff[row_d_ff] <= 1'b1;
         end
         if (cmd.op == CMD_STEP && kind == KIND_LOAD && step_wr) begin
            regs_ff[4'(cmd.cnt - 1'b1)] <= mem_q_ff;
         end
         if (fin_exec) begin
            pc_ff <= pc_next;
            sp_ff <= sp_next;
            dt_ff <= dt_next;
            st_ff <= st_next;
            if (i_set) i_ff <= i_next;
            if (push) svld_ff[sp_ff] <= 1'b1;
            if (clr_frame) fvld_ff <= '0;
            // flag write wins when vx is vf
            if (wr_x && !(wr_f && x == 4'hF)) regs_ff[x] <= x_val;
            if (wr_f) regs_ff[15] <= f_val;
         end
      end
   end

   // work registers and latched request
   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LATCH: begin
            op_ff    <= req_operation;
            addr_ff  <= req_mem_address;
            wdata_ff <= req_write_data;
            rsel_ff  <= req_row_select;
            keys_ff  <= req_keypad;
            rand_ff  <= req_random_byte;
         end
         CMD_FETCH_LO: opc_hi_ff <= mem_q_ff;
         CMD_READ_X: begin
            opc_lo_ff <= mem_q_ff;
            vx_ff     <= reg_q;
         end
         CMD_READ_Y: begin
            vy_ff  <= reg_q;
            hit_ff <= 1'b0;
         end
         CMD_STEP: begin
            if (kind == KIND_DRAW && step_wr && |(frame_old & sprite_m)) begin
               hit_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result register, loaded once per request
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_FINISH) begin
         if (op_ff == OP_EXEC) begin
            res_pc_ff   <= pc_next;
            res_opc_ff  <= opc;
            res_chg_ff  <= chg;
            res_snd_ff  <= (st_next != 8'd0);
            res_wait_ff <= waiting;
            res_bad_ff  <= bad;
            res_row_ff  <= 64'd0;
         end else begin
            res_pc_ff   <= pc_ff;
            res_opc_ff  <= 16'd0;
            res_chg_ff  <= 1'b0;
            res_snd_ff  <= (st_ff != 8'd0);
            res_wait_ff <= 1'b0;
            res_bad_ff  <= 1'b0;
            res_row_ff  <= (op_ff == OP_ROW) ? frame_old : 64'd0;
         end
      end
   end

   assign rsp_program_counter = res_pc_ff;
   assign rsp_fetched_opcode  = res_opc_ff;
   assign rsp_screen_changed  = res_chg_ff;
   assign rsp_sound_on        = res_snd_ff;
   assign rsp_waiting_key     = res_wait_ff;
   assign rsp_status          = res_bad_ff;
   assign rsp_row_pixels      = res_row_ff;

endmodule

// ----- bench/testbench.sv -----
// testbench: self-checking bench for the CHIP-8 interpreter top level
// depends on c8_pkg and bytecode_vm_cpu_with_sprite_display
module testbench;
   import c8_pkg::*;

   typedef struct {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [4:0]  row;
      logic [15:0] keys;
      logic [7:0]  rnd;
   } request_t;

   typedef struct {
      logic [11:0] pc;
      logic [15:0] opcode;
      logic        changed;
      logic        sound;
      logic        waiting;
      logic        status;
      logic [63:0] pixels;
   } step_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_IDLE;
   logic [11:0] req_mem_address = '0;
   logic [7:0] req_write_data = '0;
   logic [4:0] req_row_select = '0;
   logic [15:0] req_keypad = '0;
   logic [7:0] req_random_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [11:0] rsp_program_counter;
   logic [15:0] rsp_fetched_opcode;
   logic rsp_screen_changed, rsp_sound_on, rsp_waiting_key, rsp_status;
   logic [63:0] rsp_row_pixels;

   bytecode_vm_cpu_with_sprite_display i_dut (.*);

   // clock and reset
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // interpreter state mirror
   logic [7:0]  cpu_mem [MemBytes];
   logic [7:0]  cpu_v [16];
   logic [11:0] cpu_stack [StackDepth];
   int          cpu_sp;
   logic [11:0] cpu_pc, cpu_index;
   logic [7:0]  cpu_delay, cpu_sound;
   logic [63:0] cpu_frame [32];

   request_t     pending_q [$];
   step_result_t expected_q [$];
   int           error_count = 0;
   int           cycle_count = 0;

   initial begin
      for (int a = 0; a < MemBytes; a++) cpu_mem[a] = (a < FontBytes) ? Glyphs[a] : 8'h00;
      for (int r = 0; r < 16; r++) cpu_v[r] = 8'h00;
      for (int r = 0; r < StackDepth; r++) cpu_stack[r] = '0;
      for (int r = 0; r < 32; r++) cpu_frame[r] = '0;
      cpu_sp = 0;
      cpu_pc = PcStart;
      cpu_index = '0;
      cpu_delay = '0;
      cpu_sound = '0;
   end

   // next-state and result of one accepted request
   task automatic interpret(input request_t q, output step_result_t res);
      logic [15:0] opc;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, vx, vy;
      logic [11:0] nnn;
      logic [12:0] next;
      logic [8:0]  wide;
      logic [63:0] mask;
      logic        hit, bad;
      res = '{default: '0};
      bad = 1'b0;
      if (q.op == OP_WRITE) begin
         cpu_mem[q.addr] = q.data;
      end else if (q.op == OP_ROW) begin
         res.pixels = cpu_frame[q.row];
      end else if (q.op == OP_EXEC) begin
         opc = {cpu_mem[cpu_pc], cpu_mem[12'(cpu_pc + 1)]};
         x = opc[11:8]; y = opc[7:4]; n = opc[3:0]; kk = opc[7:0]; nnn = opc[11:0];
         vx = cpu_v[x]; vy = cpu_v[y];
         next = cpu_pc + 2;
         res.opcode = opc;
         case (opc[15:12])
            4'h0: begin
               if (opc == 16'h00E0) begin
                  for (int r = 0; r < 32; r++) cpu_frame[r] = '0;
                  res.changed = 1'b1;
               end else if (opc == 16'h00EE) begin
                  cpu_sp = (cpu_sp == 0) ? StackDepth - 1 : cpu_sp - 1;
                  next = cpu_stack[cpu_sp] + 2;
               end else bad = 1'b1;
            end
            4'h1: next = nnn;
            4'h2: begin
               cpu_stack[cpu_sp] = cpu_pc;
               cpu_sp = (cpu_sp + 1) % StackDepth;
               next = nnn;
            end
            4'h3: if (vx == kk) next = cpu_pc + 4;
            4'h4: if (vx != kk) next = cpu_pc + 4;
            4'h5: if (n != 0) bad = 1'b1; else if (vx == vy) next = cpu_pc + 4;
            4'h6: cpu_v[x] = kk;
            4'h7: cpu_v[x] = vx + kk;
            4'h8: begin
               case (n)
                  4'h0: cpu_v[x] = vy;
                  4'h1: cpu_v[x] = vx | vy;
                  4'h2: cpu_v[x] = vx & vy;
                  4'h3: cpu_v[x] = vx ^ vy;
                  4'h4: begin
                     wide = vx + vy;
                     cpu_v[x] = wide[7:0]; cpu_v[15] = {7'd0, wide[8]};
                  end
                  4'h5: begin cpu_v[x] = vx - vy; cpu_v[15] = {7'd0, vx >= vy}; end
                  4'h6: begin cpu_v[x] = vx >> 1; cpu_v[15] = {7'd0, vx[0]}; end
                  4'h7: begin cpu_v[x] = vy - vx; cpu_v[15] = {7'd0, vy >= vx}; end
                  4'hE: begin cpu_v[x] = vx << 1; cpu_v[15] = {7'd0, vx[7]}; end
                  default: bad = 1'b1;
               endcase
            end
            4'h9: if (n != 0) bad = 1'b1; else if (vx != vy) next = cpu_pc + 4;
            4'hA: cpu_index = nnn;
            4'hB: next = nnn + cpu_v[0];
            4'hC: cpu_v[x] = kk & q.rnd;
            4'hD: begin
               // sprite rows wrap in both directions
               hit = 1'b0;
               for (int r = 0; r < n; r++) begin
                  mask = {cpu_mem[12'(cpu_index + r)], 56'd0};
                  mask = 64'({mask, mask} >> vx[5:0]);
                  if ((cpu_frame[5'(vy + r)] & mask) != 0) hit = 1'b1;
                  cpu_frame[5'(vy + r)] ^= mask;
               end
               cpu_v[15] = {7'd0, hit};
               res.changed = 1'b1;
            end
            4'hE: begin
               if (kk == 8'h9E) begin
                  if (q.keys[vx[3:0]]) next = cpu_pc + 4;
               end else if (kk == 8'hA1) begin
                  if (!q.keys[vx[3:0]]) next = cpu_pc + 4;
               end else bad = 1'b1;
            end
            default: begin
               case (kk)
                  8'h07: cpu_v[x] = cpu_delay;
                  8'h0A: begin
                     if (q.keys == 0) begin
                        res.waiting = 1'b1;
                        next = cpu_pc;
                     end else begin
                        for (int k = 0; k < 16; k++) if (q.keys[k]) cpu_v[x] = 8'(k);
                     end
                  end
                  8'h15: cpu_delay = vx;
                  8'h18: cpu_sound = vx;
                  8'h1E: begin
                     cpu_v[15] = {7'd0, (cpu_index + vx) > 13'hFFF};
                     cpu_index = cpu_index + vx;
                  end
                  8'h29: cpu_index = vx[3:0] * 5;
                  8'h33: begin
                     cpu_mem[cpu_index] = vx / 100;
                     cpu_mem[12'(cpu_index + 1)] = (vx / 10) % 10;
                     cpu_mem[12'(cpu_index + 2)] = vx % 10;
                  end
                  8'h55: begin
                     for (int r = 0; r <= x; r++) cpu_mem[12'(cpu_index + r)] = cpu_v[r];
                     cpu_index = cpu_index + x + 1;
                  end
                  8'h65: begin
                     for (int r = 0; r <= x; r++) cpu_v[r] = cpu_mem[12'(cpu_index + r)];
                     cpu_index = cpu_index + x + 1;
                  end
                  default: bad = 1'b1;
               endcase
            end
         endcase
         if (bad) next = cpu_pc;
         cpu_pc = next[11:0];
         if (cpu_delay != 0) cpu_delay--;
         if (cpu_sound != 0) cpu_sound--;
      end
      res.pc = cpu_pc;
      res.sound = (cpu_sound != 0);
      res.status = bad;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request driver
   int       send_gap = 0;
   request_t in_flight;
   always @(posedge clock) begin
      step_result_t res;
      request_t     q;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            interpret(in_flight, res);
            expected_q.push_back(res);
         end
         if (req_valid && !req_ready) begin
            // hold the request until it is taken
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            q = pending_q.pop_front();
            in_flight <= q;
            req_valid <= 1'b1;
            req_operation <= q.op;
            req_mem_address <= q.addr;
            req_write_data <= q.data;
            req_row_select <= q.row;
            req_keypad <= q.keys;
            req_random_byte <= q.rnd;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and checker
   int recv_gap = 0;
   always @(posedge clock) begin
      step_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result with no request outstanding");
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_program_counter !== want.pc) begin
                  $error("program_counter exp %h got %h", want.pc, rsp_program_counter);
                  error_count++;
               end
               if (rsp_fetched_opcode !== want.opcode) begin
                  $error("fetched_opcode exp %h got %h", want.opcode, rsp_fetched_opcode);
                  error_count++;
               end
               if (rsp_screen_changed !== want.changed) begin
                  $error("screen_changed exp %b got %b", want.changed, rsp_screen_changed);
                  error_count++;
               end
               if (rsp_sound_on !== want.sound) begin
                  $error("sound_on exp %b got %b", want.sound, rsp_sound_on);
                  error_count++;
               end
               if (rsp_waiting_key !== want.waiting) begin
                  $error("waiting_key exp %b got %b", want.waiting, rsp_waiting_key);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status exp %b got %b", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_row_pixels !== want.pixels) begin
                  $error("row_pixels exp %h got %h", want.pixels, rsp_row_pixels);
                  error_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap <= pick_gap();
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // stimulus helpers
   task automatic wait_sent();
      do @(negedge clock); while (pending_q.size() != 0 || req_valid);
   endtask

   task automatic add_req(input logic [1:0] op, input logic [11:0] addr,
                          input logic [7:0] data, input logic [15:0] keys);
      request_t q;
      q.op = op; q.addr = addr; q.data = data;
      q.row = 5'($urandom); q.keys = keys; q.rnd = 8'($urandom);
      pending_q.push_back(q);
   endtask

   // write a program at the current pc and run it
   task automatic run_program(input logic [15:0] prog [$], input logic [15:0] keys [$]);
      logic [11:0] base;
      wait_sent();
      base = cpu_pc;
      foreach (prog[i]) begin
         add_req(OP_WRITE, 12'(base + 2 * i), prog[i][15:8], 16'($urandom));
         add_req(OP_WRITE, 12'(base + 2 * i + 1), prog[i][7:0], 16'($urandom));
      end
      foreach (prog[i]) add_req(OP_EXEC, '0, '0, (i < keys.size()) ? keys[i] : 16'($urandom));
   endtask

   function automatic logic [15:0] random_opcode();
      logic [15:0] r;
      int c;
      r = 16'($urandom);
      c = $urandom_range(0, 99);
      if (c < 3) return r;
      case (r[15:12])
         4'h0: return ($urandom_range(0, 1)) ? 16'h00E0 : 16'h00EE;
         4'h5, 4'h9: return {r[15:4], 4'h0};
         4'h8: return {r[15:4], 4'($urandom_range(0, 8)) == 4'd8 ? 4'hE : 4'($urandom_range(0, 7))};
         4'hD: return {r[15:4], 4'($urandom_range(0, 5))};
         4'hE: return {r[15:8], ($urandom_range(0, 1)) ? 8'h9E : 8'hA1};
         4'hF: begin
            case ($urandom_range(0, 9))
               0: return {r[15:8], 8'h07};
               1: return {r[15:8], 8'h0A};
               2: return {r[15:8], 8'h15};
               3: return {r[15:8], 8'h18};
               4: return {r[15:8], 8'h1E};
               5: return {r[15:8], 8'h29};
               6: return {r[15:8], 8'h33};
               7: return {r[15:8], 8'h55};
               8: return {r[15:8], 8'h65};
               default: return {r[15:8], 8'h18};
            endcase
         end
         default: return r;
      endcase
   endfunction

   // stimulus
   initial begin
      logic [15:0] prog [$];
      logic [15:0] keys [$];
      logic [11:0] base;
      @(negedge clock);
      // directed: alu flags, skips, sprite wrap, bcd, block moves, bad opcodes
      prog = '{16'h6AFF, 16'h6B01, 16'h8AB4, 16'h8AB5, 16'h8AB7, 16'h8AB6, 16'h8ABE,
               16'h603E, 16'h611F, 16'hA000, 16'hD01F, 16'hD010, 16'h00E0, 16'hF029,
               16'hF033, 16'hF155, 16'hF165, 16'hF01E, 16'hF00A, 16'hF00A, 16'hE09E,
               16'hE0A1, 16'h5010, 16'h8008, 16'hF0FF};
      keys.delete();
      for (int i = 0; i < 25; i++) keys.push_back(16'hFFFF);
      keys[18] = 16'h0000; keys[19] = 16'h8001; keys[20] = 16'h0000; keys[21] = 16'h0000;
      run_program(prog, keys);
      add_req(OP_ROW, '0, '0, '0);
      add_req(OP_IDLE, 12'hFFF, 8'hFF, 16'hFFFF);
      prog = '{16'h0123, 16'h9011, 16'hE0FF, 16'h30FF, 16'h40FF, 16'hC0FF, 16'h6FFF,
               16'hAFF0, 16'hFF1E, 16'hF015, 16'hF018, 16'hF007, 16'hB0FF};
      keys.delete();
      run_program(prog, keys);
      // call chain deep enough to wrap the return stack, then unwind
      wait_sent();
      base = cpu_pc;
      prog.delete();
      for (int i = 0; i < StackDepth + 2; i++) prog.push_back({4'h2, 12'(base + 2 * (i + 1))});
      run_program(prog, keys);
      prog.delete();
      for (int i = 0; i < StackDepth + 3; i++) prog.push_back(16'h00EE);
      run_program(prog, keys);
      // random programs
      for (int seg = 0; seg < 37; seg++) begin
         if (seg == 18) begin
            wait_sent();
            do @(negedge clock); while (expected_q.size() != 0);
         end
         prog.delete();
         keys.delete();
         for (int i = 0; i < 6; i++) begin
            prog.push_back(random_opcode());
            keys.push_back(($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
         end
         if ($urandom_range(0, 2) == 0) prog[0] = {4'hA, 4'h3, 8'($urandom)};
         run_program(prog, keys);
         add_req(OP_ROW, '0, '0, '0);
         if ($urandom_range(0, 3) == 0)
            add_req(OP_WRITE, 12'($urandom_range(12'h500, 12'hFFF)), 8'($urandom),
                    16'($urandom));
         if ($urandom_range(0, 9) == 0) add_req(OP_IDLE, 12'($urandom), 8'($urandom), '0);
      end
      // drain and finish
      wait_sent();
      do @(negedge clock); while (expected_q.size() != 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
